// ===== sv/dfl_pkg.sv =====
// shared types, codes and constants for the door, fan and lamp controller
package dfl_pkg;

  // event kinds
  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_BYTE   = 3'd1;
  localparam logic [2:0] CMD_MOTION = 3'd2;
  localparam logic [2:0] CMD_LIGHT  = 3'd3;
  localparam logic [2:0] CMD_TEMP   = 3'd4;

  // command characters
  localparam logic [7:0] CH_CLOSE  = 8'h32;  // '2'
  localparam logic [7:0] CH_OPEN   = 8'h33;  // '3'
  localparam logic [7:0] CH_TOGGLE = 8'h35;  // '5'
  localparam logic [7:0] CH_REPORT = 8'h36;  // '6'
  localparam logic [7:0] CH_UP     = 8'h2B;  // '+'
  localparam logic [7:0] CH_DOWN   = 8'h2D;  // '-'
  localparam logic [7:0] CH_AUTO   = 8'h61;  // 'a'
  localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] CH_ONE    = 8'h31;  // '1'

  // configuration register indexes
  localparam int unsigned CfgAddrW = 5;
  localparam logic [2:0] REG_TRAVEL = 3'd0;
  localparam logic [2:0] REG_LOW    = 3'd1;
  localparam logic [2:0] REG_MID    = 3'd2;
  localparam logic [2:0] REG_HIGH   = 3'd3;
  localparam logic [2:0] REG_TOP    = 3'd4;

  // reset values of the configuration registers
  localparam logic [15:0] TRAVEL_RST = 16'd10000;
  localparam logic [7:0]  LOW_RST    = 8'd25;
  localparam logic [7:0]  MID_RST    = 8'd28;
  localparam logic [7:0]  HIGH_RST   = 8'd32;
  localparam logic [7:0]  TOP_RST    = 8'd36;

  // fan duty values
  localparam logic [7:0] DUTY_0 = 8'd0;
  localparam logic [7:0] DUTY_1 = 8'd60;
  localparam logic [7:0] DUTY_2 = 8'd120;
  localparam logic [7:0] DUTY_3 = 8'd200;

  typedef enum logic [1:0] {
    DOOR_IDLE    = 2'd0,
    DOOR_OPENING = 2'd1,
    DOOR_LOCKED  = 2'd2,
    DOOR_CLOSING = 2'd3
  } door_e;

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_A    = 2'd1,
    PEND_B    = 2'd2
  } pend_e;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] rx_byte;
    logic       light_over;
    logic [7:0] temperature;
  } in_item_t;

  typedef struct packed {
    logic       motor_forward;
    logic       motor_reverse;
    logic       lamp_on;
    logic [7:0] fan_duty;
    logic       reply_valid;
    logic [7:0] reply_byte;
  } out_item_t;

  typedef struct packed {
    logic [15:0] travel_ticks;
    logic [7:0]  band_low;
    logic [7:0]  band_mid;
    logic [7:0]  band_high;
    logic [7:0]  band_top;
  } cfg_t;

  // fan level to pwm compare value
  function automatic logic [7:0] duty_of(logic [1:0] level);
    logic [7:0] d;
    case (level)
      2'd0:    d = DUTY_0;
      2'd1:    d = DUTY_1;
      2'd2:    d = DUTY_2;
      default: d = DUTY_3;
    endcase
    return d;
  endfunction

endpackage

// ===== sv/dfl_in_if.sv =====
// event channel: valid/ready with one event item
interface dfl_in_if;
  logic               valid;
  logic               ready;
  dfl_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/dfl_out_if.sv =====
// result channel: valid/ready with one result item
interface dfl_out_if;
  logic               valid;
  logic               ready;
  dfl_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/dfl_cfg_regs.sv =====
// apb configuration registers: travel time and fan temperature bands
module dfl_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dfl_pkg::CfgAddrW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output dfl_pkg::cfg_t                 cfg_o
);

  dfl_pkg::cfg_t cfg_q;
  logic          wr_en;
  logic [2:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[dfl_pkg::CfgAddrW-1:2];
  assign cfg_o   = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.travel_ticks <= dfl_pkg::TRAVEL_RST;
      cfg_q.band_low     <= dfl_pkg::LOW_RST;
      cfg_q.band_mid     <= dfl_pkg::MID_RST;
      cfg_q.band_high    <= dfl_pkg::HIGH_RST;
      cfg_q.band_top     <= dfl_pkg::TOP_RST;
    end else if (wr_en) begin
      case (reg_idx)
        dfl_pkg::REG_TRAVEL: cfg_q.travel_ticks <= pwdata[15:0];
        dfl_pkg::REG_LOW:    cfg_q.band_low     <= pwdata[7:0];
        dfl_pkg::REG_MID:    cfg_q.band_mid     <= pwdata[7:0];
        dfl_pkg::REG_HIGH:   cfg_q.band_high    <= pwdata[7:0];
        dfl_pkg::REG_TOP:    cfg_q.band_top     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      dfl_pkg::REG_TRAVEL: prdata = {16'd0, cfg_q.travel_ticks};
      dfl_pkg::REG_LOW:    prdata = {24'd0, cfg_q.band_low};
      dfl_pkg::REG_MID:    prdata = {24'd0, cfg_q.band_mid};
      dfl_pkg::REG_HIGH:   prdata = {24'd0, cfg_q.band_high};
      dfl_pkg::REG_TOP:    prdata = {24'd0, cfg_q.band_top};
      default:             prdata = 32'd0;
    endcase
  end

endmodule

// ===== sv/dfl_ctrl.sv =====
// controller state and the single-pass event and evaluation logic
module dfl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  dfl_pkg::in_item_t  item_i,
  input  dfl_pkg::cfg_t      cfg_i,
  output dfl_pkg::out_item_t res_o
);

  dfl_pkg::door_e door_q, door_d;
  dfl_pkg::pend_e door_pend_q, door_pend_d;
  dfl_pkg::pend_e lamp_pend_q, lamp_pend_d;
  dfl_pkg::pend_e fan_pend_q, fan_pend_d;
  logic        motion_q, motion_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic        light_q, light_d;
  logic        lamp_q, lamp_d;
  logic [1:0]  fan_q, fan_d;
  logic [7:0]  temp_q, temp_d;
  logic        door_man_q, door_man_d;
  logic        lamp_man_q, lamp_man_d;
  logic        fan_man_q, fan_man_d;
  logic        rv;
  logic [7:0]  rb;
  logic        auto_go;
  logic        moving;

  // door state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      door_q <= dfl_pkg::DOOR_IDLE;
    end else if (step_i) begin
      door_q <= door_d;
    end
  end

  // remaining control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      door_pend_q <= dfl_pkg::PEND_NONE;
      lamp_pend_q <= dfl_pkg::PEND_NONE;
      fan_pend_q  <= dfl_pkg::PEND_NONE;
      motion_q    <= 1'b0;
      elapsed_q   <= 16'd0;
      light_q     <= 1'b0;
      lamp_q      <= 1'b0;
      fan_q       <= 2'd0;
      temp_q      <= 8'd0;
      door_man_q  <= 1'b0;
      lamp_man_q  <= 1'b0;
      fan_man_q   <= 1'b0;
    end else if (step_i) begin
      door_pend_q <= door_pend_d;
      lamp_pend_q <= lamp_pend_d;
      fan_pend_q  <= fan_pend_d;
      motion_q    <= motion_d;
      elapsed_q   <= elapsed_d;
      light_q     <= light_d;
      lamp_q      <= lamp_d;
      fan_q       <= fan_d;
      temp_q      <= temp_d;
      door_man_q  <= door_man_d;
      lamp_man_q  <= lamp_man_d;
      fan_man_q   <= fan_man_d;
    end
  end

  // event first, then one evaluation pass over door, lamp and fan
  always_comb begin
    door_d      = door_q;
    door_pend_d = door_pend_q;
    lamp_pend_d = lamp_pend_q;
    fan_pend_d  = fan_pend_q;
    motion_d    = motion_q;
    elapsed_d   = elapsed_q;
    light_d     = light_q;
    lamp_d      = lamp_q;
    fan_d       = fan_q;
    temp_d      = temp_q;
    door_man_d  = door_man_q;
    lamp_man_d  = lamp_man_q;
    fan_man_d   = fan_man_q;
    rv          = 1'b0;
    rb          = 8'd0;
    moving      = (door_q == dfl_pkg::DOOR_OPENING) || (door_q == dfl_pkg::DOOR_CLOSING);

    // apply the event
    case (item_i.command)
      dfl_pkg::CMD_TICK: begin
        if (moving && (elapsed_q != 16'hFFFF)) begin
          elapsed_d = elapsed_q + 16'd1;
        end
      end
      dfl_pkg::CMD_BYTE: begin
        case (item_i.rx_byte)
          dfl_pkg::CH_CLOSE: begin
            door_man_d  = 1'b1;
            door_pend_d = dfl_pkg::PEND_B;
            rv          = 1'b1;
            rb          = ((door_q == dfl_pkg::DOOR_CLOSING) ||
                           (door_q == dfl_pkg::DOOR_IDLE)) ? dfl_pkg::CH_ZERO
                                                            : dfl_pkg::CH_ONE;
          end
          dfl_pkg::CH_OPEN: begin
            door_man_d  = 1'b1;
            door_pend_d = dfl_pkg::PEND_A;
            rv          = 1'b1;
            rb          = ((door_q == dfl_pkg::DOOR_OPENING) ||
                           (door_q == dfl_pkg::DOOR_LOCKED)) ? dfl_pkg::CH_ZERO
                                                             : dfl_pkg::CH_ONE;
          end
          dfl_pkg::CH_TOGGLE: begin
            lamp_man_d  = 1'b1;
            lamp_pend_d = dfl_pkg::PEND_A;
          end
          dfl_pkg::CH_REPORT: begin
            lamp_pend_d = dfl_pkg::PEND_B;
          end
          dfl_pkg::CH_UP: begin
            fan_man_d  = 1'b1;
            fan_pend_d = dfl_pkg::PEND_A;
          end
          dfl_pkg::CH_DOWN: begin
            fan_man_d  = 1'b1;
            fan_pend_d = dfl_pkg::PEND_B;
          end
          dfl_pkg::CH_AUTO: begin
            door_man_d  = 1'b0;
            lamp_man_d  = 1'b0;
            fan_man_d   = 1'b0;
            door_pend_d = dfl_pkg::PEND_NONE;
            lamp_pend_d = dfl_pkg::PEND_NONE;
            fan_pend_d  = dfl_pkg::PEND_NONE;
          end
          default: ;
        endcase
      end
      dfl_pkg::CMD_MOTION: motion_d = 1'b1;
      dfl_pkg::CMD_LIGHT:  light_d  = item_i.light_over;
      dfl_pkg::CMD_TEMP:   temp_d   = item_i.temperature;
      default: ;
    endcase

    // door: start travel, then check for end of travel
    auto_go = motion_d && !door_man_d;
    if ((door_d == dfl_pkg::DOOR_IDLE) &&
        (auto_go || (door_man_d && (door_pend_d == dfl_pkg::PEND_A)))) begin
      door_d      = dfl_pkg::DOOR_OPENING;
      elapsed_d   = 16'd0;
      door_pend_d = dfl_pkg::PEND_NONE;
    end
    if ((door_d == dfl_pkg::DOOR_LOCKED) &&
        (auto_go || (door_man_d && (door_pend_d == dfl_pkg::PEND_B)))) begin
      door_d      = dfl_pkg::DOOR_CLOSING;
      elapsed_d   = 16'd0;
      door_pend_d = dfl_pkg::PEND_NONE;
    end
    if (((door_d == dfl_pkg::DOOR_OPENING) || (door_d == dfl_pkg::DOOR_CLOSING)) &&
        (elapsed_d >= cfg_i.travel_ticks)) begin
      door_d   = (door_d == dfl_pkg::DOOR_OPENING) ? dfl_pkg::DOOR_LOCKED
                                                   : dfl_pkg::DOOR_IDLE;
      motion_d = 1'b0;
    end

    // lamp: follow light in auto, toggle or report in manual
    if (!lamp_man_d) begin
      lamp_d = light_d;
    end else if (lamp_pend_d != dfl_pkg::PEND_NONE) begin
      if (lamp_pend_d == dfl_pkg::PEND_A) begin
        lamp_d = !lamp_d;
      end else if ((lamp_pend_d == dfl_pkg::PEND_B) && !rv) begin
        rv = 1'b1;
        rb = lamp_d ? dfl_pkg::CH_ONE : dfl_pkg::CH_ZERO;
      end
      lamp_pend_d = dfl_pkg::PEND_NONE;
    end

    // fan: temperature bands in auto, step up or down in manual
    if (!fan_man_d) begin
      if (temp_d < cfg_i.band_low) begin
        fan_d = 2'd0;
      end else if (temp_d <= cfg_i.band_mid) begin
        fan_d = 2'd1;
      end else if (temp_d <= cfg_i.band_high) begin
        fan_d = 2'd2;
      end else if (temp_d <= cfg_i.band_top) begin
        fan_d = 2'd3;
      end
    end else if (fan_pend_d != dfl_pkg::PEND_NONE) begin
      if (fan_pend_d == dfl_pkg::PEND_A) begin
        fan_d = fan_d + 2'd1;
      end else if ((fan_pend_d == dfl_pkg::PEND_B) && (fan_d != 2'd0)) begin
        fan_d = fan_d - 2'd1;
      end
      fan_pend_d = dfl_pkg::PEND_NONE;
    end
  end

  // result of this pass
  assign res_o.motor_forward = (door_d == dfl_pkg::DOOR_OPENING);
  assign res_o.motor_reverse = (door_d == dfl_pkg::DOOR_CLOSING);
  assign res_o.lamp_on       = lamp_d;
  assign res_o.fan_duty      = dfl_pkg::duty_of(fan_d);
  assign res_o.reply_valid   = rv;
  assign res_o.reply_byte    = rb;

endmodule

// ===== sv/door_fan_lamp_controller_core.sv =====
// top level: event input register, controller pass, result register, apb config
// a taken event is held in the input register until the result register can take it
// throughput: one event per cycle unless res_o stalls; state updates in a single pass
// the path from the input register through the band compares sets the clock period
// reset: rst_ni clears state to door idle, all auto, nothing pending, default config
module door_fan_lamp_controller_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  dfl_in_if.sink                        evt_i,
  dfl_out_if.source                     res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dfl_pkg::CfgAddrW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  dfl_pkg::cfg_t      cfg;
  dfl_pkg::in_item_t  in_q;
  dfl_pkg::out_item_t out_q;
  dfl_pkg::out_item_t step_res;
  logic               in_valid_q;
  logic               out_valid_q;
  logic               advance;

  // move the held event through when the result register is free or being read out
  assign advance     = in_valid_q && (!out_valid_q || res_o.ready);
  assign evt_i.ready = !in_valid_q || advance;
  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  dfl_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dfl_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (step_res)
  );

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (evt_i.ready) begin
      in_valid_q <= evt_i.valid;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (evt_i.valid && evt_i.ready) begin
      in_q <= evt_i.data;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= step_res;
    end
  end

`ifndef SYNTH
  a_motor_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.motor_forward && out_q.motor_reverse))
    else $error("motor driven both ways");

  a_reply_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.reply_valid) |-> (out_q.reply_byte == 8'd0))
    else $error("reply byte set without reply");

  a_duty_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_q.fan_duty == dfl_pkg::DUTY_0) ||
                     (out_q.fan_duty == dfl_pkg::DUTY_1) ||
                     (out_q.fan_duty == dfl_pkg::DUTY_2) ||
                     (out_q.fan_duty == dfl_pkg::DUTY_3)))
    else $error("fan duty not a table value");

  a_held_event_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_q)))
    else $error("held event lost while stalled");
`endif

endmodule
